// ===== src/blpt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blpt_pkg
// shared types, constants and tables for the bar and peak level tracker
// ----------------------------------------------------------------------------
package blpt_pkg;

    localparam int BANDS   = 64;
    localparam int BAND_W  = $clog2(BANDS);
    localparam int MAG_W   = 24;
    localparam int LVL_W   = 16;
    localparam int SPD_W   = 24;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [SPD_W-1:0] SPEED_RESTART = 24'd655;
    localparam logic [14:0]      LOG10_2_Q16   = 15'd19729;

    typedef enum logic [1:0] {
        REG_LEVEL_CAP     = 2'd0,
        REG_LOG_GAIN      = 2'd1,
        REG_BAR_FALL_STEP = 2'd2,
        REG_PEAK_ACCEL    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [LVL_W-1:0] bar;
        logic [LVL_W-1:0] peak;
        logic [SPD_W-1:0] speed;
    } band_state_t;

    typedef struct packed {
        logic              valid;
        logic [BAND_W-1:0] band;
        logic [LVL_W-1:0]  height;
    } target_t;

    localparam logic [11:0] LOG2_FRAC [64] = '{
        12'd0,    12'd92,   12'd182,  12'd271,  12'd358,  12'd445,  12'd530,  12'd613,
        12'd696,  12'd778,  12'd858,  12'd937,  12'd1016, 12'd1093, 12'd1169, 12'd1244,
        12'd1319, 12'd1392, 12'd1465, 12'd1536, 12'd1607, 12'd1677, 12'd1746, 12'd1814,
        12'd1882, 12'd1949, 12'd2015, 12'd2080, 12'd2145, 12'd2208, 12'd2272, 12'd2334,
        12'd2396, 12'd2457, 12'd2518, 12'd2578, 12'd2637, 12'd2696, 12'd2754, 12'd2812,
        12'd2869, 12'd2926, 12'd2982, 12'd3037, 12'd3092, 12'd3146, 12'd3200, 12'd3254,
        12'd3307, 12'd3359, 12'd3412, 12'd3463, 12'd3514, 12'd3565, 12'd3615, 12'd3665,
        12'd3715, 12'd3764, 12'd3812, 12'd3861, 12'd3908, 12'd3956, 12'd4003, 12'd4050
    };

endpackage
`default_nettype wire

// ===== src/bar_peak_level_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bar_peak_level_tracker
// per-band bar and peak-hold level meter with accelerating peak fall
// ----------------------------------------------------------------------------
// usage:
//   item channel (item_valid/item_ready) carries band_index and magnitude;
//   result channel (result_valid/result_ready) carries band_out, bar_level
//   and peak_level, one result word per item word, in order
//   registers must be written over the apb port only while the block is
//   idle; the user is bound by this, the block itself does not enforce it
// pipeline and throughput:
//   an item word passes the input register, two stages of log and gain
//   arithmetic, one read-modify-write stage on the band memory, and the
//   result register; one word per cycle is sustained while result_ready is
//   high; same-band words in consecutive cycles use a write-back bypass
// reset:
//   the pipeline empties, registers take their defaults and a 64-bit valid
//   map marks every band as zero, so no clearing pass is needed
// stalls:
//   while result_ready is low and a result is waiting the whole pipeline
//   holds and item_ready stays low, even when inner stages are empty
// ----------------------------------------------------------------------------
module bar_peak_level_tracker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [blpt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [blpt_pkg::DATA_W-1:0]  pwdata,
    output logic      [blpt_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire logic [blpt_pkg::BAND_W-1:0]  band_index,
    input  wire logic [blpt_pkg::MAG_W-1:0]   magnitude,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output logic      [blpt_pkg::BAND_W-1:0]  band_out,
    output logic      [blpt_pkg::LVL_W-1:0]   bar_level,
    output logic      [blpt_pkg::LVL_W-1:0]   peak_level
);
    import blpt_pkg::*;

    logic [LVL_W-1:0]  level_cap_reg;
    logic [LVL_W-1:0]  log_gain_reg;
    logic [LVL_W-1:0]  bar_fall_step_reg;
    logic [LVL_W-1:0]  peak_accel_reg;

    band_state_t       state_mem [BANDS];
    logic [BANDS-1:0]  written_reg;

    target_t           target;
    logic              advance;
    logic              cfg_write;
    reg_index_t        cfg_index;

    logic              s4_valid_reg;
    logic [BAND_W-1:0] s4_band_reg;
    logic [LVL_W-1:0]  s4_height_reg;
    band_state_t       rd_data_reg;
    logic              rd_written_reg;

    logic              fwd_valid_reg;
    logic [BAND_W-1:0] fwd_band_reg;
    band_state_t       fwd_data_reg;

    logic              out_valid_reg;
    logic [BAND_W-1:0] band_out_reg;
    logic [LVL_W-1:0]  bar_level_reg;
    logic [LVL_W-1:0]  peak_level_reg;

    band_state_t       cur;
    band_state_t       upd;
    logic [LVL_W-1:0]  bar_drop;
    logic [LVL_W-1:0]  bar_new;
    logic [LVL_W-1:0]  peak_drop;
    logic [LVL_W-1:0]  peak_dec;
    logic [39:0]       speed_prod;
    logic [27:0]       speed_scaled;
    logic [SPD_W-1:0]  speed_cap;
    logic [SPD_W-1:0]  speed_sat;

    assign advance    = !out_valid_reg || result_ready;
    assign item_ready = advance;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign cfg_index  = reg_index_t'(paddr[3:2]);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_cap_reg     <= 16'd16128;
            log_gain_reg      <= 16'd2560;
            bar_fall_step_reg <= 16'd358;
            peak_accel_reg    <= 16'd4588;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LEVEL_CAP:     level_cap_reg     <= pwdata[LVL_W-1:0];
                REG_LOG_GAIN:      log_gain_reg      <= pwdata[LVL_W-1:0];
                REG_BAR_FALL_STEP: bar_fall_step_reg <= pwdata[LVL_W-1:0];
                REG_PEAK_ACCEL:    peak_accel_reg    <= pwdata[LVL_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_LEVEL_CAP:     prdata = {16'd0, level_cap_reg};
            REG_LOG_GAIN:      prdata = {16'd0, log_gain_reg};
            REG_BAR_FALL_STEP: prdata = {16'd0, bar_fall_step_reg};
            REG_PEAK_ACCEL:    prdata = {16'd0, peak_accel_reg};
            default:           prdata = '0;
        endcase
    end

    blpt_target u_target (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .load       (item_valid),
        .band_index (band_index),
        .magnitude  (magnitude),
        .log_gain   (log_gain_reg),
        .level_cap  (level_cap_reg),
        .target     (target)
    );

    // band memory, read in stage 3, written back in stage 4
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_data_reg <= state_mem[target.band];
            if (s4_valid_reg)
            begin
                state_mem[s4_band_reg] <= upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            s4_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            rd_written_reg <= written_reg[target.band];
            if (s4_valid_reg)
            begin
                written_reg[s4_band_reg] <= 1'b1;
            end
            s4_valid_reg  <= target.valid;
            fwd_valid_reg <= s4_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_band_reg    <= target.band;
            s4_height_reg  <= target.height;
            fwd_band_reg   <= s4_band_reg;
            fwd_data_reg   <= upd;
            band_out_reg   <= s4_band_reg;
            bar_level_reg  <= upd.bar;
            peak_level_reg <= upd.peak;
        end
    end

    // band update
    always_comb
    begin
        if (fwd_valid_reg && (fwd_band_reg == s4_band_reg))
        begin
            cur = fwd_data_reg;
        end
        else if (rd_written_reg)
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = '0;
        end

        bar_drop  = (bar_fall_step_reg >= cur.bar) ? '0 : cur.bar - bar_fall_step_reg;
        bar_new   = (s4_height_reg > cur.bar) ? s4_height_reg : bar_drop;
        peak_drop = cur.speed[SPD_W-1:8];
        peak_dec  = (peak_drop >= cur.peak) ? '0 : cur.peak - peak_drop;

        speed_prod   = cur.speed * peak_accel_reg;
        speed_scaled = speed_prod[39:12];
        speed_cap    = {level_cap_reg, 8'd0};
        speed_sat    = (speed_scaled > {4'd0, speed_cap}) ? speed_cap
                                                          : speed_scaled[SPD_W-1:0];

        if ((s4_height_reg > cur.bar) && (s4_height_reg > cur.peak))
        begin
            upd.bar   = s4_height_reg;
            upd.peak  = s4_height_reg;
            upd.speed = SPEED_RESTART;
        end
        else if (cur.peak == '0)
        begin
            upd.bar   = bar_new;
            upd.peak  = cur.peak;
            upd.speed = cur.speed;
        end
        else
        begin
            upd.bar   = bar_new;
            upd.peak  = (peak_dec < bar_new) ? bar_new : peak_dec;
            upd.speed = speed_sat;
        end
    end

    assign result_valid = out_valid_reg;
    assign band_out     = band_out_reg;
    assign bar_level    = bar_level_reg;
    assign peak_level   = peak_level_reg;

endmodule
`default_nettype wire

// ===== src/blpt_target.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blpt_target
// three-stage pipeline turning a magnitude into a clamped target height
// ----------------------------------------------------------------------------
module blpt_target (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic                       load,
    input  wire logic [blpt_pkg::BAND_W-1:0] band_index,
    input  wire logic [blpt_pkg::MAG_W-1:0]  magnitude,
    input  wire logic [blpt_pkg::LVL_W-1:0]  log_gain,
    input  wire logic [blpt_pkg::LVL_W-1:0]  level_cap,
    output blpt_pkg::target_t               target
);
    import blpt_pkg::*;

    logic              s1_valid_reg;
    logic [BAND_W-1:0] s1_band_reg;
    logic [MAG_W-1:0]  s1_mag_reg;

    logic              s2_valid_reg;
    logic [BAND_W-1:0] s2_band_reg;
    logic [15:0]       s2_lg_reg;

    logic              s3_valid_reg;
    logic [BAND_W-1:0] s3_band_reg;
    logic [31:0]       s3_prod_reg;

    logic [4:0]        lead;
    logic [MAG_W-1:0]  shifted;
    logic [5:0]        frac_idx;
    logic [15:0]       lg_next;
    logic [46:0]       prod2;
    logic [17:0]       raw_height;

    // leading one, fraction index and log2(magnitude/256) in Q.12, zero below 256
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (s1_mag_reg[i])
            begin
                lead = 5'(i);
            end
        end
        shifted  = s1_mag_reg >> (lead - 5'd6);
        frac_idx = shifted[5:0];
        if (lead >= 5'd8)
        begin
            lg_next = {4'(lead - 5'd8), 12'd0} + {4'd0, LOG2_FRAC[frac_idx]};
        end
        else
        begin
            lg_next = '0;
        end
    end

    always_comb
    begin
        prod2      = s3_prod_reg * LOG10_2_Q16;
        raw_height = prod2[46:29];
        target.valid = s3_valid_reg;
        target.band  = s3_band_reg;
        if (raw_height > {2'd0, level_cap})
        begin
            target.height = level_cap;
        end
        else
        begin
            target.height = raw_height[LVL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= load;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_band_reg <= band_index;
            s1_mag_reg  <= magnitude;
            s2_band_reg <= s1_band_reg;
            s2_lg_reg   <= lg_next;
            s3_band_reg <= s2_band_reg;
            s3_prod_reg <= s2_lg_reg * log_gain;
        end
    end

endmodule
`default_nettype wire
